@@ rtl/core/msle_pkg.sv @@
// Shared types and constants of the breakpoint linear envelope unit.
// No dependencies; every other file of the block imports this package.
package msle_pkg;

   // Default sizing
   localparam int MAX_SEGMENTS_DEF  = 16;
   localparam int DURATION_BITS_DEF = 24;

   // Fixed field widths
   localparam int LEVEL_W     = 32;  // Q16.16 breakpoint level and sample
   localparam int ACC_W       = 48;  // Q16.32 accumulator and slope
   localparam int FRAC_SHIFT  = 16;  // Q16.16 to Q16.32
   localparam int CNT_W       = 32;  // sample and segment end counters
   localparam int OPCODE_W    = 2;
   localparam int INDEX_W     = 5;
   localparam int SEG_OUT_W   = 4;
   localparam int SEGCNT_W    = 5;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 5;
   localparam int DIV_CNT_W   = $clog2(ACC_W);

   // Input operations
   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK    = 2'd0,
      OP_WRITE   = 2'd1,
      OP_RETRIG  = 2'd2
   } opcode_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEGMENT_COUNT = 2'd0,
      CSR_HOLD_AT_END   = 2'd1,
      CSR_REPEAT_ENABLE = 2'd2
   } csr_index_type;

   // Segment load sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD0,
      ST_RD1,
      ST_RD2,
      ST_DIV,
      ST_DONE
   } state_type;

   // What the sequencer does with the new slope
   typedef enum logic {
      MODE_START,
      MODE_ADVANCE
   } mode_type;

endpackage

@@ rtl/core/msle_if.sv @@
// Channel interfaces of the envelope unit: request, response and CSR write.
// Depends on msle_pkg for field widths.

interface msle_req_if import msle_pkg::*; #(
   parameter int DUR_W = DURATION_BITS_DEF
);
   logic                      valid;
   logic                      ready;
   logic [OPCODE_W-1:0]       opcode;
   logic [INDEX_W-1:0]        entry_index;
   logic signed [LEVEL_W-1:0] entry_level;
   logic [DUR_W-1:0]          entry_duration;

   modport source (output valid, opcode, entry_index, entry_level, entry_duration,
                   input ready);
   modport sink   (input valid, opcode, entry_index, entry_level, entry_duration,
                   output ready);
endinterface

interface msle_rsp_if import msle_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic signed [LEVEL_W-1:0] sample;
   logic [SEG_OUT_W-1:0]      segment_index;
   logic                      finished;

   modport source (output valid, sample, segment_index, finished, input ready);
   modport sink   (input valid, sample, segment_index, finished, output ready);
endinterface

interface msle_csr_if import msle_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/multi_segment_linear_envelope_unit.sv @@
// Breakpoint linear envelope unit. A tick's response is registered and presented in the cycle
// after acceptance. A plain tick or table write leaves the sequencer idle. A tick that enters a
// new segment, or a retrigger, busies the block: three table memory reads, a 48-step radix-2
// slope divider and an update state. Reset is synchronous: control and envelope state clear
// and config takes its defaults; the breakpoint memories keep no reset.
// Depends on msle_pkg and the channel interfaces in msle_if.sv.
module multi_segment_linear_envelope_unit import msle_pkg::*; #(
   parameter int MAX_SEGMENTS  = MAX_SEGMENTS_DEF,
   parameter int DURATION_BITS = DURATION_BITS_DEF
) (
   input logic      clock,
   input logic      reset,
   msle_req_if.sink req_ch,
   msle_rsp_if.source rsp_ch,
   msle_csr_if.sink csr_ch
);

   localparam int SEG_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int LVL_AW = $clog2(MAX_SEGMENTS + 1);
   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   // Breakpoint memories (written only while idle, read only by the sequencer)
   logic signed [LEVEL_W-1:0] level_mem [MAX_SEGMENTS+1];
   logic [DURATION_BITS-1:0]  dur_mem   [MAX_SEGMENTS];
   logic signed [LEVEL_W-1:0] lvl_rd_ff;
   logic [DURATION_BITS-1:0]  dur_rd_ff;
   logic [LVL_AW-1:0]         lvl_raddr;
   logic [SEG_W-1:0]          dur_raddr;
   logic                      lvl_we;
   logic                      dur_we;

   // Configuration
   logic [SEGCNT_W-1:0] seg_cnt_ff;
   logic                hold_ff;
   logic                repeat_en_ff;

   // Envelope state
   state_type                 state_ff, state_in;
   mode_type                  mode_ff, mode_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          end_ff, end_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [ACC_W-1:0]   slope_ff, slope_in;
   logic [SEG_W-1:0]          seg_ff, seg_in;
   logic signed [LEVEL_W-1:0] target_ff, target_in;

   // Segment load and divider
   logic [SEG_W-1:0]          seg_new_ff, seg_new_in;
   logic signed [LEVEL_W-1:0] lvl_lo_ff, lvl_lo_in;
   logic [DURATION_BITS-1:0]  dur_ff, dur_in;
   logic [DURATION_BITS-1:0]  rem_ff, rem_in;
   logic [ACC_W-1:0]          quo_ff, quo_in;
   logic [DIV_CNT_W-1:0]      div_cnt_ff, div_cnt_in;
   logic                      neg_ff, neg_in;

   // Response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [LEVEL_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic [SEG_OUT_W-1:0]      rsp_seg_ff, rsp_seg_in;
   logic                      rsp_fin_ff, rsp_fin_in;

   // Datapath helpers
   logic                      req_accept;
   logic [SEG_W-1:0]          seg_last;
   logic signed [ACC_W-1:0]   acc_step;
   logic signed [ACC_W-1:0]   acc_step_new;
   logic [CNT_W-1:0]          count_inc;
   logic [CNT_W-1:0]          end_adv;
   logic [DURATION_BITS-1:0]  div_d;
   logic [DURATION_BITS:0]    trial;
   logic                      trial_ge;
   logic signed [LEVEL_W:0]   diff;
   logic [LEVEL_W:0]          diff_mag;
   logic signed [ACC_W-1:0]   slope_new;

   function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                       input logic signed [ACC_W-1:0] b);
      logic signed [ACC_W:0] s;
      s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (s[ACC_W] != s[ACC_W-1]) begin
         sat_add = s[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         sat_add = s[ACC_W-1:0];
      end
   endfunction

   // Last segment in use: zero acts as one, above the table size as the table size
   always_comb begin
      if (seg_cnt_ff == '0) begin
         seg_last = '0;
      end else if (int'(seg_cnt_ff) > MAX_SEGMENTS) begin
         seg_last = SEG_W'(MAX_SEGMENTS - 1);
      end else begin
         seg_last = SEG_W'(seg_cnt_ff - 1'b1);
      end
   end

   // Saturating accumulator and counter arithmetic
   always_comb begin
      logic [CNT_W:0] end_sum;
      acc_step     = sat_add(acc_ff, slope_ff);
      acc_step_new = sat_add(acc_ff, slope_new);
      count_inc    = (count_ff == {CNT_W{1'b1}}) ? count_ff : count_ff + 1'b1;
      end_sum      = {1'b0, end_ff} + (CNT_W+1)'(dur_ff);
      end_adv      = end_sum[CNT_W] ? {CNT_W{1'b1}} : end_sum[CNT_W-1:0];
   end

   // Divider step and slope sign and saturation
   always_comb begin
      div_d    = (dur_ff == '0) ? DURATION_BITS'(1) : dur_ff;
      trial    = {rem_ff, quo_ff[ACC_W-1]};
      trial_ge = (trial >= {1'b0, div_d});
      diff     = {lvl_rd_ff[LEVEL_W-1], lvl_rd_ff} - {lvl_lo_ff[LEVEL_W-1], lvl_lo_ff};
      diff_mag = diff[LEVEL_W] ? (~diff + 1'b1) : diff;
      if (!neg_ff) begin
         slope_new = quo_ff[ACC_W-1] ? ACC_MAX : quo_ff;
      end else if (quo_ff[ACC_W-1] && (quo_ff[ACC_W-2:0] != '0)) begin
         slope_new = ACC_MIN;
      end else begin
         slope_new = ~quo_ff + 1'b1;
      end
   end

   // Only a tick needs the response slot
   assign req_ch.ready = (state_ff == ST_IDLE) &&
                         (!rsp_valid_ff || rsp_ch.ready || (req_ch.opcode != OP_TICK));

   assign req_accept = req_ch.valid && req_ch.ready;

   // Next state and outputs
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      count_in      = count_ff;
      end_in        = end_ff;
      acc_in        = acc_ff;
      slope_in      = slope_ff;
      seg_in        = seg_ff;
      target_in     = target_ff;
      seg_new_in    = seg_new_ff;
      lvl_lo_in     = lvl_lo_ff;
      dur_in        = dur_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      div_cnt_in    = div_cnt_ff;
      neg_in        = neg_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_seg_in    = rsp_seg_ff;
      rsp_fin_in    = rsp_fin_ff;
      lvl_raddr     = '0;
      dur_raddr     = '0;
      lvl_we        = 1'b0;
      dur_we        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (opcode_type'(req_ch.opcode))
                  OP_WRITE: begin
                     lvl_we = (int'(req_ch.entry_index) <= MAX_SEGMENTS);
                     dur_we = (int'(req_ch.entry_index) < MAX_SEGMENTS);
                  end
                  OP_RETRIG: begin
                     seg_new_in = '0;
                     mode_in    = MODE_START;
                     state_in   = ST_RD0;
                  end
                  OP_TICK: begin
                     rsp_valid_in  = 1'b1;
                     rsp_sample_in = acc_ff[ACC_W-1:FRAC_SHIFT];
                     rsp_seg_in    = SEG_OUT_W'(seg_ff);
                     rsp_fin_in    = 1'b0;
                     if (count_ff < end_ff) begin
                        acc_in   = acc_step;
                        count_in = count_inc;
                     end else if (seg_ff < seg_last) begin
                        seg_new_in = seg_ff + 1'b1;
                        mode_in    = MODE_ADVANCE;
                        state_in   = ST_RD0;
                     end else if (repeat_en_ff) begin
                        seg_new_in = '0;
                        mode_in    = MODE_START;
                        state_in   = ST_RD0;
                     end else begin
                        rsp_fin_in = 1'b1;
                        acc_in     = hold_ff ? {target_ff, {FRAC_SHIFT{1'b0}}} : acc_step;
                        count_in   = count_inc;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_RD0: begin
            // Fetch the segment's start level and duration
            lvl_raddr = LVL_AW'(seg_new_ff);
            dur_raddr = seg_new_ff;
            state_in  = ST_RD1;
         end
         ST_RD1: begin
            // Fetch the segment's end level
            lvl_lo_in = lvl_rd_ff;
            dur_in    = dur_rd_ff;
            lvl_raddr = LVL_AW'(seg_new_ff) + 1'b1;
            state_in  = ST_RD2;
         end
         ST_RD2: begin
            // Load the divider with |diff| * 2^16
            target_in  = lvl_rd_ff;
            neg_in     = diff[LEVEL_W];
            quo_in     = {diff_mag[LEVEL_W-1:0], {FRAC_SHIFT{1'b0}}};
            rem_in     = '0;
            div_cnt_in = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            // One quotient bit per cycle
            quo_in     = {quo_ff[ACC_W-2:0], trial_ge};
            rem_in     = trial_ge ? DURATION_BITS'(trial - {1'b0, div_d})
                                  : DURATION_BITS'(trial);
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(ACC_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            slope_in = slope_new;
            seg_in   = seg_new_ff;
            if (mode_ff == MODE_START) begin
               count_in = '0;
               end_in   = CNT_W'(dur_ff);
               acc_in   = {lvl_lo_ff, {FRAC_SHIFT{1'b0}}};
            end else begin
               end_in = end_adv;
               acc_in = acc_step_new;
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Breakpoint memories: one write, one registered read each
   always_ff @(posedge clock) begin
      if (lvl_we) begin
         level_mem[LVL_AW'(req_ch.entry_index)] <= req_ch.entry_level;
      end
      if (dur_we) begin
         dur_mem[SEG_W'(req_ch.entry_index)] <= DURATION_BITS'(req_ch.entry_duration);
      end
      lvl_rd_ff <= level_mem[lvl_raddr];
      dur_rd_ff <= dur_mem[dur_raddr];
   end

   // Configuration writes, accepted every cycle
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_cnt_ff   <= SEGCNT_W'(1);
         hold_ff      <= 1'b1;
         repeat_en_ff <= 1'b0;
      end else if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_SEGMENT_COUNT: seg_cnt_ff   <= SEGCNT_W'(csr_ch.data);
            CSR_HOLD_AT_END:   hold_ff      <= csr_ch.data[0];
            CSR_REPEAT_ENABLE: repeat_en_ff <= csr_ch.data[0];
            default: ;
         endcase
      end
   end

   // Control and envelope state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         end_ff       <= '0;
         acc_ff       <= '0;
         slope_ff     <= '0;
         seg_ff       <= '0;
         target_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         end_ff       <= end_in;
         acc_ff       <= acc_in;
         slope_ff     <= slope_in;
         seg_ff       <= seg_in;
         target_ff    <= target_in;
      end
   end

   // Sequencer and response payload
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      seg_new_ff    <= seg_new_in;
      lvl_lo_ff     <= lvl_lo_in;
      dur_ff        <= dur_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      div_cnt_ff    <= div_cnt_in;
      neg_ff        <= neg_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_seg_ff    <= rsp_seg_in;
      rsp_fin_ff    <= rsp_fin_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.sample        = rsp_sample_ff;
   assign rsp_ch.segment_index = rsp_seg_ff;
   assign rsp_ch.finished      = rsp_fin_ff;

   // A tick always leaves a response behind
   a_tick_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_ch.opcode == OP_TICK) |=> rsp_valid_ff)
      else $error("tick accepted without response");

   // Divider never runs past its last quotient bit
   a_div_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (int'(div_cnt_ff) < ACC_W))
      else $error("divider step count out of range");

   // Slope update always returns to idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle");

   // A restart lands on segment zero with a cleared count
   a_start_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && mode_ff == MODE_START) |=> (seg_ff == '0 && count_ff == '0))
      else $error("restart did not clear segment and count");

   // Segment stays inside the table
   a_seg_range: assert property (@(posedge clock) disable iff (reset)
      int'(seg_ff) < MAX_SEGMENTS)
      else $error("segment index beyond table");

endmodule

@@ test/multi_segment_linear_envelope_unit_test.sv @@
`timescale 1ns / 100ps
// Testbench of the breakpoint linear envelope unit: a directed table and extremes pass, then
// randomized envelope runs under several register settings, scored against an envelope predictor.
// Depends on msle_pkg, the channel interfaces of msle_if.sv and multi_segment_linear_envelope_unit.
module multi_segment_linear_envelope_unit_test;
   import msle_pkg::*;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 5;
   localparam int SETTLE_CYCLES = 64;    // long enough for the slope load after a retrigger
   localparam int STALL_LIMIT   = 2000;
   localparam int MAX_PRINTED   = 50;
   localparam int PHASE_ITEMS   = 120;
   localparam int PHASE_COUNT   = 8;
   localparam int TABLE_TOP     = MAX_SEGMENTS_DEF;   // last breakpoint, level only

   localparam logic [OPCODE_W-1:0]  OP_UNDEFINED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED   = 2'd3;

   localparam longint ACC_TOP     = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint ACC_BOTTOM  = -ACC_TOP - 1;
   localparam longint COUNT_TOP   = 64'sh0000_0000_FFFF_FFFF;
   localparam longint LEVEL_SCALE = 64'sd1 << FRAC_SHIFT;

   typedef struct packed {
      logic signed [LEVEL_W-1:0] sample;
      logic [SEG_OUT_W-1:0]      segment_index;
      logic                      finished;
   } envelope_point_type;

   logic clock = 1'b0;
   logic reset;

   msle_req_if #(.DUR_W(DURATION_BITS_DEF)) req_ch ();
   msle_rsp_if                              rsp_ch ();
   msle_csr_if                              csr_ch ();

   multi_segment_linear_envelope_unit #(
      .MAX_SEGMENTS  (MAX_SEGMENTS_DEF),
      .DURATION_BITS (DURATION_BITS_DEF)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Predicted envelope state and register copies
   logic signed [LEVEL_W-1:0]    level_mem [0:MAX_SEGMENTS_DEF];
   logic [DURATION_BITS_DEF-1:0] span_mem  [0:MAX_SEGMENTS_DEF-1];
   logic [CNT_W-1:0]             env_count;
   logic [CNT_W-1:0]             env_end;
   logic signed [ACC_W-1:0]      env_level;
   logic signed [ACC_W-1:0]      env_slope;
   logic [SEG_OUT_W-1:0]         env_segment;
   logic signed [LEVEL_W-1:0]    env_target;
   logic [SEGCNT_W-1:0]          cfg_segments;
   logic                         cfg_hold;
   logic                         cfg_repeat;

   envelope_point_type pending_samples [$];

   int error_count    = 0;
   int items_accepted = 0;
   int samples_seen   = 0;
   int csr_writes     = 0;
   int stall_cycles   = 0;
   bit steady         = 1'b0;   // no idling on either side while set

   always #HALF_PERIOD clock = ~clock;

   task automatic report_mismatch(input string what);
      error_count++;
      // limit log volume on a badly broken build
      if (error_count <= MAX_PRINTED)
         $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   // Saturate to the 48-bit Q16.32 range
   function automatic logic signed [ACC_W-1:0] clamp_level(input longint value);
      if (value > ACC_TOP)
         return ACC_W'(ACC_TOP);
      if (value < ACC_BOTTOM)
         return ACC_W'(ACC_BOTTOM);
      return ACC_W'(value);
   endfunction

   function automatic logic [CNT_W-1:0] count_add(input logic [CNT_W-1:0] base,
                                                  input longint amount);
      longint total;
      total = longint'(base) + amount;
      if (total > COUNT_TOP)
         return '1;
      return CNT_W'(total);
   endfunction

   function automatic int unsigned segments_active();
      if (cfg_segments < 1)
         return 1;
      if (cfg_segments > MAX_SEGMENTS_DEF)
         return MAX_SEGMENTS_DEF;
      return cfg_segments;
   endfunction

   // Level step per sample, truncated toward zero; a zero span counts as one sample
   function automatic logic signed [ACC_W-1:0] segment_slope(input int unsigned seg);
      longint rise;
      longint span;
      rise = longint'(level_mem[seg + 1]) - longint'(level_mem[seg]);
      span = longint'(span_mem[seg]);
      if (span == 0)
         span = 1;
      return clamp_level((rise * LEVEL_SCALE) / span);
   endfunction

   function automatic void restart_envelope();
      env_segment = '0;
      env_count   = '0;
      env_target  = level_mem[1];
      env_end     = CNT_W'(span_mem[0]);
      env_level   = ACC_W'(longint'(level_mem[0]) * LEVEL_SCALE);
      env_slope   = segment_slope(0);
   endfunction

   // Apply one accepted item; a tick queues the sample it must produce
   function automatic void step_envelope(input logic [OPCODE_W-1:0] op,
                                         input logic [INDEX_W-1:0] idx,
                                         input logic signed [LEVEL_W-1:0] lvl,
                                         input logic [DURATION_BITS_DEF-1:0] span);
      envelope_point_type point;
      int unsigned        last_seg;
      case (op)
         OP_WRITE: begin
            if (idx <= TABLE_TOP) begin
               level_mem[idx] = lvl;
               if (idx < TABLE_TOP)
                  span_mem[idx] = span;
            end
         end
         OP_RETRIG: begin
            restart_envelope();
         end
         OP_TICK: begin
            last_seg            = segments_active() - 1;
            point.sample        = env_level[ACC_W-1:FRAC_SHIFT];
            point.segment_index = env_segment;
            point.finished      = 1'b0;
            if (env_count < env_end) begin
               env_level = clamp_level(longint'(env_level) + longint'(env_slope));
               env_count = count_add(env_count, 1);
            end else if (env_segment < last_seg) begin
               // enter the next segment; the count stays put
               env_segment = env_segment + 1'b1;
               env_target  = level_mem[int'(env_segment) + 1];
               env_end     = count_add(env_end, longint'(span_mem[env_segment]));
               env_slope   = segment_slope(env_segment);
               env_level   = clamp_level(longint'(env_level) + longint'(env_slope));
            end else if (cfg_repeat) begin
               restart_envelope();
            end else begin
               point.finished = 1'b1;
               if (cfg_hold)
                  env_level = ACC_W'(longint'(env_target) * LEVEL_SCALE);
               else
                  env_level = clamp_level(longint'(env_level) + longint'(env_slope));
               env_count = count_add(env_count, 1);
            end
            pending_samples.push_back(point);
         end
         default: begin
         end
      endcase
   endfunction

   // Present one item, hold it until accepted, then predict
   task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [INDEX_W-1:0] idx,
                            input logic signed [LEVEL_W-1:0] lvl,
                            input logic [DURATION_BITS_DEF-1:0] span);
      if (!steady && $urandom_range(0, 99) < 20) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.opcode         <= op;
      req_ch.entry_index    <= idx;
      req_ch.entry_level    <= lvl;
      req_ch.entry_duration <= span;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      step_envelope(op, idx, lvl, span);
      items_accepted++;
   endtask

   // Tick with random don't-care fields
   task automatic send_tick();
      send_item(OP_TICK, INDEX_W'($urandom), LEVEL_W'($urandom), DURATION_BITS_DEF'($urandom));
   endtask

   function automatic logic signed [LEVEL_W-1:0] random_level();
      if ($urandom_range(0, 9) < 4)
         return LEVEL_W'($urandom);
      return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
   endfunction

   // Mostly short spans so runs get through many segments
   function automatic logic [DURATION_BITS_DEF-1:0] random_span();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 85)
         return DURATION_BITS_DEF'($urandom_range(0, 5));
      if (pick < 95)
         return DURATION_BITS_DEF'($urandom_range(0, 255));
      return DURATION_BITS_DEF'($urandom);
   endfunction

   function automatic logic [INDEX_W-1:0] random_index();
      if ($urandom_range(0, 9) == 0)
         return INDEX_W'($urandom_range(0, 31));
      return INDEX_W'($urandom_range(0, TABLE_TOP));
   endfunction

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         CSR_SEGMENT_COUNT: cfg_segments = data;
         CSR_HOLD_AT_END:   cfg_hold     = data[0];
         CSR_REPEAT_ENABLE: cfg_repeat   = data[0];
         default: begin
         end
      endcase
      csr_writes++;
   endtask

   // Drain, let any slope load finish, then rewrite all registers
   task automatic apply_settings(input logic [SEGCNT_W-1:0] segs, input logic hold,
                                 input logic rpt, input bit poke_unused);
      req_ch.valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_register(CSR_SEGMENT_COUNT, segs);
      write_register(CSR_HOLD_AT_END, CSR_DATA_W'(hold));
      write_register(CSR_REPEAT_ENABLE, CSR_DATA_W'(rpt));
      if (poke_unused)
         write_register(CSR_UNUSED, CSR_DATA_W'($urandom));
      csr_ch.valid <= 1'b0;
   endtask

   // Ticks from the reset state, before any table entry exists
   task automatic test_tick_before_retrigger();
      repeat (2) send_tick();
   endtask

   // Extreme levels and spans, ignored items, saturation and a zero-span segment
   task automatic test_table_extremes();
      int i;
      send_item(OP_WRITE, 5'd0, 32'sh8000_0000, 24'd1);
      send_item(OP_WRITE, 5'd1, 32'sh7FFF_FFFF, 24'd0);
      send_item(OP_WRITE, 5'd2, 32'sh0000_0000, 24'd3);
      send_item(OP_WRITE, 5'd3, -32'sd65536, 24'd2);
      for (i = 4; i < TABLE_TOP; i++)
         send_item(OP_WRITE, INDEX_W'(i), LEVEL_W'(i * 4096),
                   (i == TABLE_TOP - 1) ? 24'hFF_FFFF : 24'd2);
      send_item(OP_WRITE, INDEX_W'(TABLE_TOP), 32'sh0001_0000, 24'hFF_FFFF);
      send_item(OP_WRITE, INDEX_W'(TABLE_TOP + 1), 32'sh1234_5678, 24'd5);
      send_item(OP_UNDEFINED, '1, '1, '1);
      apply_settings(5'd4, 1'b1, 1'b0, 1'b0);
      send_item(OP_RETRIG, '0, '0, '0);
      repeat (8) send_tick();
   endtask

   // Bursts of table edits, a retrigger and a run of ticks, with some noise mixed in
   task automatic run_envelope_bursts(input int budget);
      int                 counted;
      int                 writes;
      int                 ticks;
      logic [INDEX_W-1:0] idx;
      counted = 0;
      while (counted < budget) begin
         writes = $urandom_range(0, 3);
         repeat (writes) begin
            idx = random_index();
            send_item(OP_WRITE, idx, random_level(), random_span());
            if (idx <= TABLE_TOP)
               counted++;
         end
         // most bursts restart; the rest keep the running envelope
         if ($urandom_range(0, 9) != 0) begin
            send_item(OP_RETRIG, INDEX_W'($urandom), LEVEL_W'($urandom),
                      DURATION_BITS_DEF'($urandom));
            counted++;
         end
         ticks = $urandom_range(4, 90);
         repeat (ticks) begin
            case ($urandom_range(0, 99))
               0, 1: begin
                  send_item(OP_UNDEFINED, INDEX_W'($urandom), LEVEL_W'($urandom),
                            DURATION_BITS_DEF'($urandom));
               end
               2, 3: begin
                  idx = random_index();
                  send_item(OP_WRITE, idx, random_level(), random_span());
                  if (idx <= TABLE_TOP)
                     counted++;
               end
               default: begin
                  send_tick();
                  counted++;
               end
            endcase
         end
      end
   endtask

   // Walk the register settings, extremes included, one random phase each
   task automatic test_random_settings();
      logic [SEGCNT_W-1:0] seg_plan [0:PHASE_COUNT-1];
      logic [PHASE_COUNT-1:0] hold_plan;
      logic [PHASE_COUNT-1:0] repeat_plan;
      int phase;
      seg_plan    = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd17, 5'd1, 5'd0, 5'd4};
      hold_plan   = 8'b1001_0101;
      repeat_plan = 8'b1000_1100;
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase == 6)
            apply_settings(SEGCNT_W'($urandom_range(1, MAX_SEGMENTS_DEF)),
                           1'($urandom), 1'($urandom), 1'b1);
         else
            apply_settings(seg_plan[phase], hold_plan[phase], repeat_plan[phase], 1'b0);
         // one phase runs flat out on both sides
         steady = (phase == 4);
         run_envelope_bursts(PHASE_ITEMS);
      end
      steady = 1'b0;
   endtask

   // Score each accepted sample and drive the receiver's ready
   always @(posedge clock) begin : score_samples
      envelope_point_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_samples.size() == 0) begin
            report_mismatch($sformatf("unexpected sample %h segment %0d finished %0b",
                                      rsp_ch.sample, rsp_ch.segment_index, rsp_ch.finished));
         end else begin
            want = pending_samples.pop_front();
            if (rsp_ch.sample !== want.sample)
               report_mismatch($sformatf("sample %0d: level %h, want %h",
                                         samples_seen, rsp_ch.sample, want.sample));
            if (rsp_ch.segment_index !== want.segment_index)
               report_mismatch($sformatf("sample %0d: segment %0d, want %0d",
                                         samples_seen, rsp_ch.segment_index,
                                         want.segment_index));
            if (rsp_ch.finished !== want.finished)
               report_mismatch($sformatf("sample %0d: finished %0b, want %0b",
                                         samples_seen, rsp_ch.finished, want.finished));
            samples_seen++;
         end
      end
      rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 20);
   end

   // End the run when no channel moves an item for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles, %0d samples outstanding",
                  stall_cycles, pending_samples.size());
         $display("tb: failure");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      // predictor matches the post-reset state
      foreach (level_mem[i])
         level_mem[i] = '0;
      foreach (span_mem[i])
         span_mem[i] = '0;
      env_count    = '0;
      env_end      = '0;
      env_level    = '0;
      env_slope    = '0;
      env_segment  = '0;
      env_target   = '0;
      cfg_segments = SEGCNT_W'(1);
      cfg_hold     = 1'b1;
      cfg_repeat   = 1'b0;

      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.opcode         <= OP_TICK;
      req_ch.entry_index    <= '0;
      req_ch.entry_level    <= '0;
      req_ch.entry_duration <= '0;
      csr_ch.valid          <= 1'b0;
      csr_ch.index          <= CSR_SEGMENT_COUNT;
      csr_ch.data           <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_tick_before_retrigger();
      test_table_extremes();
      test_random_settings();

      // drain and let the block settle
      req_ch.valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("summary: %0d items accepted, %0d samples scored, %0d register writes",
               items_accepted, samples_seen, csr_writes);
      $display("summary: %0d setting phases, %0d mismatches", PHASE_COUNT + 1, error_count);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
